### src/dns_erb_pkg.sv
package dns_erb_pkg;

    localparam logic [15:0] HDR_BYTES        = 16'd12;
    localparam logic [15:0] MIN_QUESTION_LEN = 16'd17;
    localparam logic [15:0] MIN_QUERY_LEN    = 16'd2;
    localparam logic [15:0] CAP_RESET        = 16'd272;
    localparam logic [7:0]  MAX_LABEL_LEN    = 8'd63;
    localparam logic [7:0]  QR_RA_BIT        = 8'h80;
    localparam logic [7:0]  FLAGS_ECHO_MASK  = 8'h79;

    // byte positions inside the query header
    localparam logic [15:0] POS_ID_HI   = 16'd0;
    localparam logic [15:0] POS_ID_LO   = 16'd1;
    localparam logic [15:0] POS_FLAGS   = 16'd2;
    localparam logic [15:0] POS_QDC_HI  = 16'd4;
    localparam logic [15:0] POS_QDC_LO  = 16'd5;

    // label walk phases
    localparam logic [1:0] PHASE_WALKING = 2'd0;
    localparam logic [1:0] PHASE_FOUND   = 2'd1;
    localparam logic [1:0] PHASE_BAD     = 2'd2;

    // register byte addresses
    localparam logic [2:0] ADDR_REPLY_CAPACITY = 3'd0;

    typedef struct packed {
        logic [15:0] reply_length;
        logic [15:0] message_id;
        logic [7:0]  flags_high;
        logic [7:0]  flags_low;
        logic        question_echoed;
    } res_t;

endpackage

### src/dns_erb_cfg.sv
module dns_erb_cfg (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [15:0] reply_capacity
);
    import dns_erb_pkg::*;

    logic [15:0] cap_reg;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr == ADDR_REPLY_CAPACITY);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAP_RESET;
        end
        else if (wr_en)
        begin
            cap_reg <= pwdata[15:0];
        end
    end

    always_comb
    begin
        prdata = 32'd0;
        if (paddr == ADDR_REPLY_CAPACITY)
        begin
            prdata = {16'd0, cap_reg};
        end
    end

    assign reply_capacity = cap_reg;

endmodule

### src/dns_erb_parser.sv
module dns_erb_parser #(
    parameter int MAX_QUERY_BYTES = 65535
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              acc,
    input  logic [7:0]        data_byte,
    input  logic              last_byte,
    input  logic [3:0]        error_code,
    input  logic [15:0]       reply_capacity,
    output logic              res_valid,
    output dns_erb_pkg::res_t res
);
    import dns_erb_pkg::*;

    localparam logic [15:0] MAX_POS = 16'(MAX_QUERY_BYTES);

    logic [15:0] pos_reg, pos_next;
    logic [15:0] id_reg, id_next;
    logic [7:0]  flags_reg, flags_next;
    logic        cio_reg, cio_next;
    logic [16:0] label_reg, label_next;
    logic [1:0]  phase_reg, phase_next;
    logic [15:0] name_end_reg, name_end_next;

    logic        take;
    logic [16:0] qend;
    logic        bad_query;
    logic        question_ok;

    always_comb
    begin
        take          = pos_reg < MAX_POS;
        pos_next      = pos_reg;
        id_next       = id_reg;
        flags_next    = flags_reg;
        cio_next      = cio_reg;
        label_next    = label_reg;
        phase_next    = phase_reg;
        name_end_next = name_end_reg;

        if (take)
        begin
            case (pos_reg)
                POS_ID_HI:  id_next[15:8] = data_byte;
                POS_ID_LO:  id_next[7:0]  = data_byte;
                POS_FLAGS:  flags_next    = data_byte;
                POS_QDC_HI: cio_next      = (data_byte == 8'd0);
                POS_QDC_LO: cio_next      = cio_reg && (data_byte == 8'd1);
                default:    ;
            endcase

            // follow the length bytes of the question name
            if (phase_reg == PHASE_WALKING && pos_reg >= HDR_BYTES &&
                {1'b0, pos_reg} == label_reg)
            begin
                if (data_byte == 8'd0)
                begin
                    name_end_next = pos_reg + 16'd1;
                    phase_next    = PHASE_FOUND;
                end
                else if (data_byte > MAX_LABEL_LEN)
                begin
                    phase_next = PHASE_BAD;
                end
                else
                begin
                    label_next = {1'b0, pos_reg} + 17'd1 + {9'd0, data_byte};
                end
            end
            pos_next = pos_reg + 16'd1;
        end

        qend        = {1'b0, name_end_next} + 17'd4;
        bad_query   = (pos_next < MIN_QUERY_LEN) || (reply_capacity < HDR_BYTES);
        question_ok = (pos_next >= MIN_QUESTION_LEN) && cio_next &&
                      (phase_next == PHASE_FOUND) &&
                      (qend <= {1'b0, pos_next}) && (qend <= {1'b0, reply_capacity});

        res = '0;
        if (!bad_query)
        begin
            res.message_id = id_next;
            res.flags_high = QR_RA_BIT |
                             ((pos_next > MIN_QUERY_LEN) ? (flags_next & FLAGS_ECHO_MASK)
                                                         : 8'd0);
            res.flags_low  = QR_RA_BIT | {4'd0, error_code};
            if (question_ok)
            begin
                res.reply_length    = qend[15:0];
                res.question_echoed = 1'b1;
            end
            else
            begin
                res.reply_length    = HDR_BYTES;
                res.question_echoed = 1'b0;
            end
        end
        res_valid = acc && last_byte;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= 16'd0;
            id_reg       <= 16'd0;
            flags_reg    <= 8'd0;
            cio_reg      <= 1'b0;
            label_reg    <= {1'b0, HDR_BYTES};
            phase_reg    <= PHASE_WALKING;
            name_end_reg <= 16'd0;
        end
        else if (acc)
        begin
            if (last_byte)
            begin
                // start over for the next query
                pos_reg      <= 16'd0;
                id_reg       <= 16'd0;
                flags_reg    <= 8'd0;
                cio_reg      <= 1'b0;
                label_reg    <= {1'b0, HDR_BYTES};
                phase_reg    <= PHASE_WALKING;
                name_end_reg <= 16'd0;
            end
            else
            begin
                pos_reg      <= pos_next;
                id_reg       <= id_next;
                flags_reg    <= flags_next;
                cio_reg      <= cio_next;
                label_reg    <= label_next;
                phase_reg    <= phase_next;
                name_end_reg <= name_end_next;
            end
        end
    end

endmodule

### src/dns_erb_out_buf.sv
module dns_erb_out_buf (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  dns_erb_pkg::res_t push_data,
    output logic              full,
    output logic              out_valid,
    input  logic              out_stall,
    output dns_erb_pkg::res_t out_data
);
    import dns_erb_pkg::*;

    res_t out_reg;
    res_t skid_reg;
    logic out_valid_reg;
    logic skid_valid_reg;
    logic pop;

    assign pop = out_valid_reg && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end
        else if (!out_valid_reg || pop)
        begin
            out_valid_reg <= push;
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (!out_valid_reg || pop)
        begin
            if (push)
            begin
                out_reg <= push_data;
            end
        end
        else if (push)
        begin
            // park the transaction behind the stalled one
            skid_reg <= push_data;
        end
    end

    assign full      = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

### src/dns_error_reply_builder.sv
// DNS error reply header builder.
// Input channel (in_valid / in_stall): one raw query byte per transaction in
// data_byte, with last_byte marking the final byte and error_code sampled on it.
// Output channel (out_valid / out_stall): one transaction per query, issued for
// its last byte: reply_length (0 bad input, 12 header only, else end of the
// question), message_id, flags_high, flags_low and question_echoed.
// APB port: register 0 at byte address 0 is reply_capacity (reset 272).
// Throughput: one query byte every cycle while in_stall is low; the header
// walk runs in a single combinational pass between the query state registers
// and the output register, which takes each result unless the receiver stalls.
// When the receiver stalls, one more result is held in a skid register; only
// then does in_stall rise, and it falls in the cycle after the output drains.
// Reset clears the query state, empties the output and sets reply_capacity to
// 272. Bytes past MAX_QUERY_BYTES are counted out but a last flag still ends the
// query.
module dns_error_reply_builder #(
    parameter int MAX_QUERY_BYTES = 65535
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    input  logic [3:0]  error_code,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] reply_length,
    output logic [15:0] message_id,
    output logic [7:0]  flags_high,
    output logic [7:0]  flags_low,
    output logic        question_echoed,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import dns_erb_pkg::*;

    logic [15:0] reply_capacity;
    logic        acc;
    logic        res_valid;
    logic        buf_full;
    res_t        res;
    res_t        out_data;

    assign acc      = in_valid && !buf_full;
    assign in_stall = buf_full;

    dns_erb_cfg u_cfg (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .reply_capacity (reply_capacity)
    );

    dns_erb_parser #(
        .MAX_QUERY_BYTES (MAX_QUERY_BYTES)
    ) u_parser (
        .clk            (clk),
        .rst_n          (rst_n),
        .acc            (acc),
        .data_byte      (data_byte),
        .last_byte      (last_byte),
        .error_code     (error_code),
        .reply_capacity (reply_capacity),
        .res_valid      (res_valid),
        .res            (res)
    );

    dns_erb_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .full      (buf_full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    assign reply_length    = out_data.reply_length;
    assign message_id      = out_data.message_id;
    assign flags_high      = out_data.flags_high;
    assign flags_low       = out_data.flags_low;
    assign question_echoed = out_data.question_echoed;

endmodule

### src/dns_erb_checker.sv
module dns_erb_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [15:0] reply_length,
    input logic [15:0] message_id,
    input logic [7:0]  flags_high,
    input logic [7:0]  flags_low,
    input logic        question_echoed
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(reply_length) &&
                                   $stable(message_id))
        else $error("stalled output transaction dropped or changed");

    a_bad_all_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && reply_length == 16'd0 |->
            message_id == 16'd0 && flags_high == 8'd0 && flags_low == 8'd0 &&
            !question_echoed)
        else $error("bad-input reply carries header fields");

    a_flags_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && reply_length != 16'd0 |->
            flags_high[7] && !flags_high[2] && !flags_high[1] &&
            flags_low[7] && flags_low[6:4] == 3'd0)
        else $error("reply flag bytes malformed");

    a_length_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && reply_length != 16'd0 |->
            (question_echoed && reply_length >= 16'd17) ||
            (!question_echoed && reply_length == 16'd12))
        else $error("reply length disagrees with question echo");

endmodule

bind dns_error_reply_builder dns_erb_checker u_dns_erb_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .reply_length    (reply_length),
    .message_id      (message_id),
    .flags_high      (flags_high),
    .flags_low       (flags_low),
    .question_echoed (question_echoed)
);

### verif/dns_error_reply_builder_tb.sv
module dns_error_reply_builder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dns_erb_pkg::*;

    localparam int MAX_QUERY_BYTES = 65535;
    localparam int RANDOM_BYTES    = 600;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  data_byte;
    logic        last_byte;
    logic [3:0]  error_code;
    logic        out_valid;
    logic        out_stall;
    logic [15:0] reply_length;
    logic [15:0] message_id;
    logic [7:0]  flags_high;
    logic [7:0]  flags_low;
    logic        question_echoed;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    dns_error_reply_builder #(
        .MAX_QUERY_BYTES(MAX_QUERY_BYTES)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .data_byte(data_byte),
        .last_byte(last_byte),
        .error_code(error_code),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .reply_length(reply_length),
        .message_id(message_id),
        .flags_high(flags_high),
        .flags_low(flags_low),
        .question_echoed(question_echoed),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    // predicted query state and register copy
    logic [15:0] capacity;
    logic [15:0] q_pos;
    logic [15:0] q_id;
    logic [7:0]  q_flags;
    logic        q_qd_one;
    logic [16:0] q_next_label;
    logic [1:0]  q_phase;
    logic [15:0] q_name_end;

    res_t        pending_replies[$];
    logic [7:0]  query_bytes[$];
    int          fail_count;
    int          random_bytes_sent;
    bit          gaps_on;
    bit          stall_on;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("dns_error_reply_builder_tb: FAIL");
        $finish;
    end

    function automatic void clear_query_state();
        q_pos        = '0;
        q_id         = '0;
        q_flags      = '0;
        q_qd_one     = 1'b0;
        q_next_label = {1'b0, HDR_BYTES};
        q_phase      = PHASE_WALKING;
        q_name_end   = '0;
    endfunction

    function automatic void track_query_byte(logic [7:0] b, logic lst, logic [3:0] code);
        logic [15:0] p;
        logic [16:0] qend;
        res_t        r;
        if (q_pos < MAX_QUERY_BYTES)
        begin
            p = q_pos;
            case (p)
                POS_ID_HI:  q_id[15:8] = b;
                POS_ID_LO:  q_id[7:0] = b;
                POS_FLAGS:  q_flags = b;
                POS_QDC_HI: q_qd_one = (b == 8'd0);
                POS_QDC_LO: q_qd_one = q_qd_one && (b == 8'd1);
                default: ;
            endcase
            if (q_phase == PHASE_WALKING && p >= HDR_BYTES && {1'b0, p} == q_next_label)
            begin
                if (b == 8'd0)
                begin
                    q_name_end = p + 16'd1;
                    q_phase    = PHASE_FOUND;
                end
                else if (b > MAX_LABEL_LEN)
                    q_phase = PHASE_BAD;
                else
                    q_next_label = {1'b0, p} + 17'd1 + {9'd0, b};
            end
            q_pos = p + 16'd1;
        end
        if (!lst)
            return;
        r = '0;
        if (q_pos >= MIN_QUERY_LEN && capacity >= HDR_BYTES)
        begin
            r.message_id = q_id;
            r.flags_high = QR_RA_BIT | ((q_pos > MIN_QUERY_LEN) ? (q_flags & FLAGS_ECHO_MASK)
                                                                : 8'h00);
            r.flags_low  = QR_RA_BIT | {4'd0, code};
            qend = {1'b0, q_name_end} + 17'd4;
            if (q_pos >= MIN_QUESTION_LEN && q_qd_one && q_phase == PHASE_FOUND &&
                qend <= {1'b0, q_pos} && qend <= {1'b0, capacity})
            begin
                r.reply_length    = qend[15:0];
                r.question_echoed = 1'b1;
            end
            else
                r.reply_length = HDR_BYTES;
        end
        pending_replies.push_back(r);
        clear_query_state();
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    // receiver pacing: random runs of stall and flow
    initial
    begin : sink_pacing
        int run_left;
        bit stall_now;
        run_left  = 0;
        stall_now = 1'b0;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (run_left == 0)
            begin
                stall_now = stall_on && ($urandom_range(0, 99) < 35);
                run_left  = stall_now ? pick_gap() + 1 : $urandom_range(1, 24);
            end
            run_left--;
            out_stall <= stall_now;
        end
    end

    always @(posedge clk)
    begin : reply_check
        res_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_replies.size() == 0)
            begin
                $error("unexpected reply: reply_length %0d message_id %h",
                       reply_length, message_id);
                fail_count++;
            end
            else
            begin
                want = pending_replies.pop_front();
                if (reply_length !== want.reply_length)
                begin
                    $error("reply_length expected %0d got %0d", want.reply_length, reply_length);
                    fail_count++;
                end
                if (message_id !== want.message_id)
                begin
                    $error("message_id expected %h got %h", want.message_id, message_id);
                    fail_count++;
                end
                if (flags_high !== want.flags_high)
                begin
                    $error("flags_high expected %h got %h", want.flags_high, flags_high);
                    fail_count++;
                end
                if (flags_low !== want.flags_low)
                begin
                    $error("flags_low expected %h got %h", want.flags_low, flags_low);
                    fail_count++;
                end
                if (question_echoed !== want.question_echoed)
                begin
                    $error("question_echoed expected %0b got %0b",
                           want.question_echoed, question_echoed);
                    fail_count++;
                end
            end
        end
    end

    task automatic send_byte(logic [7:0] b, logic lst, logic [3:0] code);
        int gap;
        gap = gaps_on ? pick_gap() : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid   <= 1'b1;
        data_byte  <= b;
        last_byte  <= lst;
        error_code <= code;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        track_query_byte(b, lst, code);
    endtask

    task automatic send_query(logic [3:0] code);
        int n;
        n = query_bytes.size();
        for (int i = 0; i < n; i++)
        begin
            if (i == n - 1)
                send_byte(query_bytes[i], 1'b1, code);
            else
                send_byte(query_bytes[i], 1'b0, 4'($urandom_range(0, 15)));
        end
    endtask

    // drop valid and let every reply drain before touching the register
    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_replies.size() > 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_capacity(logic [15:0] value);
        wait_idle();
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_REPLY_CAPACITY;
        pwdata  <= {16'($urandom_range(0, 65535)), value};
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        capacity = value;
    endtask

    task automatic check_capacity_readback();
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_REPLY_CAPACITY;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata !== {16'd0, capacity})
        begin
            $error("prdata expected %h got %h", {16'd0, capacity}, prdata);
            fail_count++;
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic void push_random(int n);
        for (int i = 0; i < n; i++)
            query_bytes.push_back(8'($urandom_range(0, 255)));
    endfunction

    function automatic void begin_header(logic [15:0] qdcount);
        query_bytes.delete();
        push_random(12);
        query_bytes[4] = qdcount[15:8];
        query_bytes[5] = qdcount[7:0];
    endfunction

    function automatic void push_label(int len);
        query_bytes.push_back(8'(len));
        push_random(len);
    endfunction

    function automatic int pick_label_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return $urandom_range(1, 8);
        if (r < 98)
            return $urandom_range(9, 20);
        return MAX_LABEL_LEN;
    endfunction

    function automatic void build_random_query();
        int kind;
        int keep;
        kind = $urandom_range(0, 99);
        if (kind >= 86)
        begin
            // pure noise, mostly short
            query_bytes.delete();
            push_random($urandom_range(1, 24));
            return;
        end
        if (kind >= 65 && kind < 72)
            begin_header(16'($urandom_range(2, 65535)) ^ 16'h0001 ^ 16'h0001 | 16'h0000);
        else
            begin_header(16'h0001);
        if (kind >= 65 && kind < 72 && query_bytes[4] == 8'h00 && query_bytes[5] == 8'h01)
            query_bytes[5] = 8'h02;
        repeat ($urandom_range(0, 3))
            push_label(pick_label_len());
        if (kind >= 72 && kind < 79)
        begin
            // oversized label length or compression pointer in the name
            query_bytes.push_back(8'($urandom_range(64, 255)));
            push_random($urandom_range(0, 8));
            return;
        end
        query_bytes.push_back(8'h00);
        push_random(4);
        if ($urandom_range(0, 99) < 30)
            push_random($urandom_range(1, 6));
        if (kind >= 79)
        begin
            // cut short somewhere in the query
            keep = $urandom_range(1, query_bytes.size() - 1);
            while (query_bytes.size() > keep)
                void'(query_bytes.pop_back());
        end
    endfunction

    task automatic test_reset_defaults();
        check_capacity_readback();
        begin_header(16'h0001);
        push_label(5);
        query_bytes.push_back(8'h00);
        push_random(4);
        send_query(4'd3);
        wait_idle();
    endtask

    task automatic test_short_queries();
        query_bytes.delete();
        push_random(1);
        send_query(4'd15);
        query_bytes.delete();
        push_random(2);
        send_query(4'd0);
        query_bytes.delete();
        query_bytes.push_back(8'hFF);
        query_bytes.push_back(8'h00);
        query_bytes.push_back(8'hFF);
        send_query(4'd15);
        begin_header(16'h0001);
        send_query(4'd2);
        // root label present but QTYPE/QCLASS short of 17 bytes
        begin_header(16'h0001);
        query_bytes.push_back(8'h00);
        push_random(3);
        send_query(4'd5);
        // smallest question: root name only
        begin_header(16'h0001);
        query_bytes.push_back(8'h00);
        push_random(4);
        send_query(4'd1);
        wait_idle();
    endtask

    task automatic test_header_only();
        begin_header(16'h0000);
        push_label(3);
        query_bytes.push_back(8'h00);
        push_random(4);
        send_query(4'd2);
        begin_header(16'h0002);
        push_label(3);
        query_bytes.push_back(8'h00);
        push_random(4);
        send_query(4'd4);
        begin_header(16'h0101);
        query_bytes.push_back(8'h00);
        push_random(4);
        send_query(4'd8);
        // longest legal label
        begin_header(16'h0001);
        push_label(MAX_LABEL_LEN);
        query_bytes.push_back(8'h00);
        push_random(4);
        send_query(4'd9);
        begin_header(16'h0001);
        push_label(2);
        query_bytes.push_back(MAX_LABEL_LEN + 8'd1);
        push_random(70);
        send_query(4'd3);
        // compression pointer where a label is expected
        begin_header(16'h0001);
        query_bytes.push_back(8'hC0);
        query_bytes.push_back(8'h0C);
        push_random(4);
        send_query(4'd3);
        // name never terminates
        begin_header(16'h0001);
        push_label(4);
        push_label(6);
        send_query(4'd2);
        begin_header(16'h0001);
        push_label(4);
        query_bytes.push_back(8'h00);
        push_random(3);
        send_query(4'd2);
        // question followed by extra records
        begin_header(16'h0001);
        push_label(4);
        query_bytes.push_back(8'h00);
        push_random(15);
        query_bytes[2] = 8'hFF;
        send_query(4'd15);
        wait_idle();
    endtask

    task automatic test_capacity_edges();
        logic [15:0] caps[7];
        caps = '{16'd0, 16'd11, 16'd12, 16'd20, 16'd21, 16'd65535, 16'd17};
        foreach (caps[i])
        begin
            write_capacity(caps[i]);
            check_capacity_readback();
            // question ends at byte 21
            begin_header(16'h0001);
            push_label(3);
            query_bytes.push_back(8'h00);
            push_random(4);
            send_query(4'($urandom_range(0, 15)));
        end
        write_capacity(CAP_RESET);
        wait_idle();
    endtask

    task automatic test_back_to_back();
        gaps_on  = 1'b0;
        stall_on = 1'b0;
        repeat (6)
        begin
            build_random_query();
            send_query(4'($urandom_range(0, 15)));
        end
        // full input rate against a stalling receiver
        stall_on = 1'b1;
        repeat (8)
        begin
            build_random_query();
            send_query(4'($urandom_range(0, 15)));
        end
        wait_idle();
        gaps_on = 1'b1;
    endtask

    task automatic test_random_queries();
        int sel;
        while (random_bytes_sent < RANDOM_BYTES)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 30)
                write_capacity(16'($urandom_range(12, 60)));
            else if (sel < 50)
                write_capacity(CAP_RESET);
            else if (sel < 65)
                write_capacity(16'd65535);
            else if (sel < 72)
                write_capacity(16'($urandom_range(0, 11)));
            else
                write_capacity(16'($urandom_range(0, 65535)));
            gaps_on  = ($urandom_range(0, 9) != 0);
            stall_on = ($urandom_range(0, 9) != 0);
            repeat ($urandom_range(6, 14))
            begin
                build_random_query();
                random_bytes_sent += query_bytes.size();
                send_query(4'($urandom_range(0, 15)));
            end
        end
        gaps_on  = 1'b1;
        stall_on = 1'b1;
        wait_idle();
    endtask

    initial
    begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        data_byte  = '0;
        last_byte  = 1'b0;
        error_code = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        fail_count = 0;
        random_bytes_sent = 0;
        gaps_on    = 1'b1;
        stall_on   = 1'b1;
        capacity   = CAP_RESET;
        clear_query_state();
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_short_queries();
        test_header_only();
        test_capacity_edges();
        test_back_to_back();
        test_random_queries();

        while (pending_replies.size() > 0)
            @(posedge clk);
        repeat (5) @(posedge clk);
        if (fail_count == 0)
            $display("dns_error_reply_builder_tb: PASS");
        else
            $display("dns_error_reply_builder_tb: FAIL");
        $finish;
    end

endmodule

### dns_error_reply_builder.f
src/dns_erb_pkg.sv
src/dns_erb_cfg.sv
src/dns_erb_parser.sv
src/dns_erb_out_buf.sv
src/dns_error_reply_builder.sv
src/dns_erb_checker.sv
verif/dns_error_reply_builder_tb.sv
